// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: lbl");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ===== rtl/core/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and codes of the bounded stack with search.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int CAP_W  = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;

    // operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

    // result status codes carried in m_tuser
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND  = 3'd5;

    // register addresses
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 7'd64;

    // chain movement
    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_PUSH,
        SHIFT_POP,
        SHIFT_ROT
    } shift_op_t;

    // per-cell control
    typedef struct packed {
        shift_op_t op;
        logic      active;  // cell holds a live entry
        logic      tail;    // cell holds the bottom live entry
    } cell_ctl_t;

endpackage

// ===== rtl/core/bss_cell.sv =====
// ----------------------------------------------------------------------------
// bss_cell
// One stack slot: holds a word, takes a neighbor's or top slot's word on a move.
// ----------------------------------------------------------------------------
module bss_cell (
    input  logic                       clk,
    input  bss_pkg::cell_ctl_t         ctl,
    input  logic [bss_pkg::WORD_W-1:0] up_data,    // from the slot nearer the top
    input  logic [bss_pkg::WORD_W-1:0] dn_data,    // from the slot nearer the bottom
    input  logic [bss_pkg::WORD_W-1:0] wrap_data,  // top slot, for rotation
    output logic [bss_pkg::WORD_W-1:0] data
);
    import bss_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // slot next value
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            SHIFT_PUSH: data_next = up_data;
            SHIFT_POP:  data_next = dn_data;
            SHIFT_ROT:
            begin
                if (ctl.active)
                begin
                    data_next = ctl.tail ? wrap_data : dn_data;
                end
            end
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/bss_chain.sv =====
// ----------------------------------------------------------------------------
// bss_chain
// Row of stack slots, top at slot 0; shifts for push/pop, rotates for scans.
// ----------------------------------------------------------------------------
module bss_chain #(
    parameter int DEPTH = 64,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  bss_pkg::shift_op_t         op,
    input  logic [CW-1:0]              count,
    input  logic [bss_pkg::WORD_W-1:0] push_data,
    output logic [bss_pkg::WORD_W-1:0] top_data
);
    import bss_pkg::*;

    logic [WORD_W-1:0] slot_q [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_slot
            localparam logic [CW-1:0] IDX  = CW'(k);
            localparam logic [CW-1:0] IDX1 = CW'(k + 1);

            logic [WORD_W-1:0] up_w;
            logic [WORD_W-1:0] dn_w;
            cell_ctl_t         ctl_w;

            if (k == 0)
            begin : g_first
                assign up_w = push_data;
            end
            else
            begin : g_mid_up
                assign up_w = slot_q[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign dn_w = slot_q[k];
            end
            else
            begin : g_mid_dn
                assign dn_w = slot_q[k+1];
            end

            assign ctl_w.op     = op;
            assign ctl_w.active = (IDX < count);
            assign ctl_w.tail   = (IDX1 == count);

            bss_cell u_cell (
                .clk       (clk),
                .ctl       (ctl_w),
                .up_data   (up_w),
                .dn_data   (dn_w),
                .wrap_data (slot_q[0]),
                .data      (slot_q[k])
            );
        end
    endgenerate

    assign top_data = slot_q[0];

endmodule

// ===== rtl/core/bounded_stack_with_search_top.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO stack of 32-bit words with dump and search.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser = operation, s_tdata = value. Output stream m_*:
//   m_tuser = status, m_tdata = entry word and depth, m_tlast marks the final
//   result of each input transaction. APB register 0 holds capacity.
//   Push and pop give one result the cycle after acceptance and run back to
//   back while the receiver keeps up.
//   Dump of n entries gives one result per cycle, one per entry from the
//   top, while the receiver keeps up; search of n entries steps through
//   them and then releases the held last match (or the not-found status).
//   The chain rotates one entry past its top slot per cycle while a scan steps.
//   A new transaction is taken only when no scan is running and the output
//   register is free or being drained. When the receiver stalls, the output
//   holds; a dump pauses in place, and a search pauses only to release a match.
//   Reset empties the stack and sets capacity to 64; slot contents are not
//   cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [31:0] value
    input  logic [1:0]                 s_tuser,   // [1:0] func
    // output stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata,   // [31:0] data, [38:32] position, [39] zero
    output logic [2:0]                 m_tuser,   // [2:0] status
    output logic                       m_tlast,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bss_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bss_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t              state_reg;
    logic [CAP_W-1:0]    capacity_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic                dump_reg;
    logic [WORD_W-1:0]   key_reg;
    logic                pend_valid_reg;
    logic [WORD_W-1:0]   pend_data_reg;
    logic [POS_W-1:0]    pend_pos_reg;
    logic                m_tvalid_reg;
    logic [STAT_W-1:0]   m_status_reg;
    logic [WORD_W-1:0]   m_data_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                s_acc;
    logic                full;
    logic                empty;
    logic [WORD_W-1:0]   top_data;
    logic [CW-1:0]       idx_plus1;
    logic [POS_W-1:0]    cur_pos;
    logic                at_end;
    logic                match;
    logic                need_emit;
    logic                step;
    shift_op_t           chain_op;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // handshake and scan conditions
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign full      = (CAP_W'(count_reg) >= capacity_reg) || (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign idx_plus1 = idx_reg + CW'(1);
    assign cur_pos   = POS_W'(idx_plus1);
    assign at_end    = (idx_plus1 == count_reg);
    assign match     = (top_data == key_reg);
    assign need_emit = dump_reg || (match && pend_valid_reg);
    assign step      = (state_reg == ST_SCAN) && (!need_emit || out_free);

    // chain movement
    always_comb
    begin
        chain_op = SHIFT_HOLD;
        if (s_acc && (s_tuser == FUNC_PUSH) && !full)
        begin
            chain_op = SHIFT_PUSH;
        end
        else if (s_acc && (s_tuser == FUNC_POP) && !empty)
        begin
            chain_op = SHIFT_POP;
        end
        else if (step)
        begin
            chain_op = SHIFT_ROT;
        end
    end

    bss_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain (
        .clk       (clk),
        .op        (chain_op),
        .count     (count_reg),
        .push_data (s_tdata),
        .top_data  (top_data)
    );

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            dump_reg       <= 1'b0;
            key_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_data_reg  <= '0;
            pend_pos_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_status_reg   <= STAT_OK;
            m_data_reg     <= '0;
            m_pos_reg      <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= STAT_OK;
                        m_data_reg   <= '0;
                        m_pos_reg    <= '0;
                        m_last_reg   <= 1'b1;
                        idx_reg      <= '0;
                        key_reg      <= s_tdata;
                        pend_valid_reg <= 1'b0;
                        case (s_tuser)
                            FUNC_PUSH:
                            begin
                                if (full)
                                begin
                                    m_status_reg <= STAT_OVERFLOW;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            FUNC_POP:
                            begin
                                if (empty)
                                begin
                                    m_status_reg <= STAT_UNDERFLOW;
                                end
                                else
                                begin
                                    m_data_reg <= top_data;
                                    m_pos_reg  <= POS_W'(1);
                                    count_reg  <= count_reg - CW'(1);
                                end
                            end
                            FUNC_DUMP:
                            begin
                                if (empty)
                                begin
                                    m_status_reg <= STAT_EMPTY;
                                end
                                else
                                begin
                                    m_tvalid_reg <= 1'b0;
                                    dump_reg     <= 1'b1;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                m_tvalid_reg <= 1'b0;
                                dump_reg     <= 1'b0;
                                state_reg    <= empty ? ST_FLUSH : ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (step)
                    begin
                        idx_reg <= idx_plus1;
                        if (dump_reg)
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_status_reg <= STAT_OK;
                            m_data_reg   <= top_data;
                            m_pos_reg    <= cur_pos;
                            m_last_reg   <= at_end;
                        end
                        else if (match)
                        begin
                            // release the previous match, hold this one
                            if (pend_valid_reg)
                            begin
                                m_tvalid_reg <= 1'b1;
                                m_status_reg <= STAT_FOUND;
                                m_data_reg   <= pend_data_reg;
                                m_pos_reg    <= pend_pos_reg;
                                m_last_reg   <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_data_reg  <= top_data;
                            pend_pos_reg   <= cur_pos;
                        end
                        if (at_end)
                        begin
                            state_reg <= dump_reg ? ST_IDLE : ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_last_reg   <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            m_status_reg <= STAT_FOUND;
                            m_data_reg   <= pend_data_reg;
                            m_pos_reg    <= pend_pos_reg;
                        end
                        else
                        begin
                            m_status_reg <= STAT_NOTFOUND;
                            m_data_reg   <= '0;
                            m_pos_reg    <= '0;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output ports
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_pos_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C)
    `ASSERT_NEXT(a_scan_count_stable, state_reg == ST_SCAN, count_reg == $past(count_reg))
    `ASSERT_NEXT(a_push_grows, chain_op == SHIFT_PUSH, count_reg == $past(count_reg) + CW'(1))
    `ASSERT_NEXT(a_scan_step_ok, step && !dump_reg && !at_end, state_reg == ST_SCAN)

endmodule
